>>> hdl/plds_pkg.sv
package plds_pkg;

  localparam int LANES      = 3;
  localparam int DSQ_W      = 34;
  localparam int DOT_W      = 35;
  localparam int NUM_W      = 43;
  localparam int ND_W       = 18;
  localparam int NUM_HI_W   = NUM_W - ND_W;
  localparam int LEN_W      = 25;
  localparam int ROOT_IN_W  = 2 * LEN_W;
  localparam int ROOT_W     = ROOT_IN_W + 1;
  localparam int SQRT_STEPS = LEN_W;
  localparam int PROD_W     = 58;
  localparam int EQ_W       = 56;
  localparam int PRE_W      = PROD_W - EQ_W;
  localparam int REM_W      = DSQ_W + 1;
  localparam int S_W        = EQ_W + 1;
  localparam int CFG_W      = 24;

  localparam logic [ND_W-1:0] ND_MAX = '1;
  localparam logic [S_W-1:0]  AMB_Q24 = S_W'(83886);
  localparam logic [S_W-1:0]  S_CAP = S_W'(1) << EQ_W;

  // input reg, l, squares, sums, flags, root, n.l divide, two multiplies,
  // E divide, sum select, three shade stages
  localparam int LATENCY = 5 + SQRT_STEPS + ND_W + 1 + 2 + EQ_W + 1 + 1 + 3;

  typedef enum logic [2:0] {
    REG_LIGHT_POS_X,
    REG_LIGHT_POS_Y,
    REG_LIGHT_POS_Z,
    REG_LIGHT_RED,
    REG_LIGHT_GREEN,
    REG_LIGHT_BLUE,
    REG_LIGHT_INTENSITY,
    REG_LIGHT_RANGE
  } plds_reg_e;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        mat_red;
    logic [15:0]        mat_green;
    logic [15:0]        mat_blue;
    logic [15:0]        mat_alpha;
  } plds_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } plds_out_t;

  typedef struct packed {
    logic [15:0]      mat_red;
    logic [15:0]      mat_green;
    logic [15:0]      mat_blue;
    logic [15:0]      mat_alpha;
    logic             oor;
    logic [DSQ_W-1:0] div;
  } plds_side_t;

  typedef struct packed {
    plds_side_t       side;
    logic [NUM_W-1:0] num;
  } plds_root_tag_t;

  typedef struct packed {
    logic [LANES-1:0]            sat;
    logic [LANES-1:0][EQ_W-1:0]  q;
  } plds_quot_t;

endpackage

>>> hdl/point_light_diffuse_shader_top.sv
// Point-light Lambert shader, fully pipelined.
// Throughput: one transaction per cycle; busy is high only during reset.
// Results are strobed for one cycle on res_valid_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears all pipeline valids and the light registers.
module point_light_diffuse_shader_top import plds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  plds_in_t         in_data_i,
  output logic             res_valid_o,
  output plds_out_t        res_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Light registers. The user must write them only while the pipe is empty (the
  // block does not enforce this), so every stage may read them directly.
  // ---------------------------------------------------------------------------
  logic signed [15:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0]        red_q, green_q, blue_q, range_q;
  logic [CFG_W-1:0]   inten_q;
  logic [31:0]        rsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      inten_q <= '0;
      range_q <= '0;
      rsq_q   <= '0;
    end else begin
      rsq_q <= 32'(range_q) * 32'(range_q);
      if (cfg_we_i) begin
        unique case (plds_reg_e'(cfg_idx_i))
          REG_LIGHT_POS_X:     pos_x_q <= cfg_wdata_i[15:0];
          REG_LIGHT_POS_Y:     pos_y_q <= cfg_wdata_i[15:0];
          REG_LIGHT_POS_Z:     pos_z_q <= cfg_wdata_i[15:0];
          REG_LIGHT_RED:       red_q   <= cfg_wdata_i[15:0];
          REG_LIGHT_GREEN:     green_q <= cfg_wdata_i[15:0];
          REG_LIGHT_BLUE:      blue_q  <= cfg_wdata_i[15:0];
          REG_LIGHT_INTENSITY: inten_q <= cfg_wdata_i;
          REG_LIGHT_RANGE:     range_q <= cfg_wdata_i[15:0];
        endcase
      end
    end
  end

  // No back-pressure anywhere: a transaction is taken whenever start is high.
  assign busy = ~rst_ni;

  // ---------------------------------------------------------------------------
  // Front end: input register, L vector, squares and n*l terms, sums, flags.
  // ---------------------------------------------------------------------------
  logic     s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  plds_in_t s1_in_q, s2_in_q, s3_in_q, s4_in_q;

  logic signed [16:0] l_q  [LANES];
  logic signed [16:0] l_d  [LANES];
  logic [31:0]        sq_q [LANES];
  logic signed [32:0] dt_q [LANES];
  logic signed [33:0] sq_full [LANES];
  logic signed [32:0] dt_d [LANES];
  logic signed [15:0] nrm [LANES];

  logic [DSQ_W-1:0]        dsq_q;
  logic signed [DOT_W-1:0] dot_q;

  always_comb begin
    l_d[0] = $signed({pos_x_q[15], pos_x_q}) - $signed({s1_in_q.point_x[15], s1_in_q.point_x});
    l_d[1] = $signed({pos_y_q[15], pos_y_q}) - $signed({s1_in_q.point_y[15], s1_in_q.point_y});
    l_d[2] = $signed({pos_z_q[15], pos_z_q}) - $signed({s1_in_q.point_z[15], s1_in_q.point_z});
    nrm[0] = s2_in_q.normal_x;
    nrm[1] = s2_in_q.normal_y;
    nrm[2] = s2_in_q.normal_z;
    for (int j = 0; j < LANES; j++) begin
      sq_full[j] = 34'(l_q[j]) * 34'(l_q[j]);
      dt_d[j]    = 33'(nrm[j]) * 33'(l_q[j]);
    end
  end

  // stage 5 flags
  plds_root_tag_t   root_tag_d, root_tag_q;
  logic             root_valid_q;
  logic [ROOT_IN_W-1:0] root_x_q;
  logic             dot_pos;

  always_comb begin
    dot_pos                 = !dot_q[DOT_W-1] && (dot_q != '0) && (dsq_q != '0);
    root_tag_d.num          = dot_pos ? {dot_q[32:0], 10'b0} : '0;
    root_tag_d.side.mat_red   = s4_in_q.mat_red;
    root_tag_d.side.mat_green = s4_in_q.mat_green;
    root_tag_d.side.mat_blue  = s4_in_q.mat_blue;
    root_tag_d.side.mat_alpha = s4_in_q.mat_alpha;
    root_tag_d.side.oor     = (range_q != '0) && (dsq_q > {2'b0, rsq_q});
    root_tag_d.side.div     = (dsq_q == '0) ? DSQ_W'(1) : dsq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      root_valid_q <= 1'b0;
    end else begin
      s1_valid_q   <= start;
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      s4_valid_q   <= s3_valid_q;
      root_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_in_q <= in_data_i;
    s2_in_q <= s1_in_q;
    s3_in_q <= s2_in_q;
    s4_in_q <= s3_in_q;
    for (int j = 0; j < LANES; j++) begin
      l_q[j]  <= l_d[j];
      sq_q[j] <= sq_full[j][31:0];
      dt_q[j] <= dt_d[j];
    end
    dsq_q <= {2'b0, sq_q[0]} + {2'b0, sq_q[1]} + {2'b0, sq_q[2]};
    dot_q <= {{2{dt_q[0][32]}}, dt_q[0]} + {{2{dt_q[1][32]}}, dt_q[1]} +
             {{2{dt_q[2][32]}}, dt_q[2]};
    root_tag_q <= root_tag_d;
    root_x_q   <= {dsq_q, 16'b0};
  end

  // ---------------------------------------------------------------------------
  // |L| in units of 2^-16.
  // ---------------------------------------------------------------------------
  logic           rt_valid;
  logic [LEN_W-1:0] rt_len;
  plds_root_tag_t rt_tag;

  plds_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_valid_q),
    .x_i     (root_x_q),
    .tag_i   (root_tag_q),
    .valid_o (rt_valid),
    .root_o  (rt_len),
    .tag_o   (rt_tag)
  );

  // ---------------------------------------------------------------------------
  // n.l = (n.L << 10) / |L|, one quotient bit per stage, capped.
  // ---------------------------------------------------------------------------
  logic [NUM_HI_W:0] nd_rem_q [ND_W+1];
  logic [ND_W-1:0]   nd_acc_q [ND_W+1];
  logic [LEN_W-1:0]  nd_len_q [ND_W+1];
  logic              nd_sat_q [ND_W+1];
  logic              nd_nz_q  [ND_W+1];
  logic              nd_valid_q [ND_W+1];
  plds_side_t        nd_side_q  [ND_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_valid_q[0] <= 1'b0;
    end else begin
      nd_valid_q[0] <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    nd_rem_q[0]  <= {1'b0, rt_tag.num[NUM_W-1:ND_W]};
    nd_acc_q[0]  <= rt_tag.num[ND_W-1:0];
    nd_len_q[0]  <= rt_len;
    nd_sat_q[0]  <= rt_tag.num[NUM_W-1:ND_W] >= rt_len;
    nd_nz_q[0]   <= rt_tag.num != '0;
    nd_side_q[0] <= rt_tag.side;
  end

  for (genvar k = 1; k <= ND_W; k++) begin : g_nd
    logic [NUM_HI_W:0] shifted;
    logic              ge;

    assign shifted = {nd_rem_q[k-1][NUM_HI_W-1:0], nd_acc_q[k-1][ND_W-1]};
    assign ge      = shifted >= {1'b0, nd_len_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nd_valid_q[k] <= 1'b0;
      end else begin
        nd_valid_q[k] <= nd_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      nd_rem_q[k]  <= ge ? shifted - {1'b0, nd_len_q[k-1]} : shifted;
      nd_acc_q[k]  <= {nd_acc_q[k-1][ND_W-2:0], ge};
      nd_len_q[k]  <= nd_len_q[k-1];
      nd_sat_q[k]  <= nd_sat_q[k-1];
      nd_nz_q[k]   <= nd_nz_q[k-1];
      nd_side_q[k] <= nd_side_q[k-1];
    end
  end

  logic [ND_W-1:0] ndotl;
  always_comb begin
    priority if (!nd_nz_q[ND_W]) begin
      ndotl = '0;
    end else if (nd_sat_q[ND_W]) begin
      ndotl = ND_MAX;
    end else begin
      ndotl = nd_acc_q[ND_W];
    end
  end

  // ---------------------------------------------------------------------------
  // color * n.l, then * intensity.
  // ---------------------------------------------------------------------------
  logic [15:0]        col [LANES];
  logic [33:0]        cn_q [LANES];
  logic [LANES-1:0][PROD_W-1:0] prod_q;
  logic               ma_valid_q, mb_valid_q;
  plds_side_t         ma_side_q, mb_side_q;

  assign col[0] = red_q;
  assign col[1] = green_q;
  assign col[2] = blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_valid_q <= 1'b0;
      mb_valid_q <= 1'b0;
    end else begin
      ma_valid_q <= nd_valid_q[ND_W];
      mb_valid_q <= ma_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_side_q <= nd_side_q[ND_W];
    mb_side_q <= ma_side_q;
    for (int j = 0; j < LANES; j++) begin
      cn_q[j]   <= 34'(col[j]) * 34'(ndotl);
      prod_q[j] <= PROD_W'(cn_q[j]) * PROD_W'(inten_q);
    end
  end

  // ---------------------------------------------------------------------------
  // E = product / max(distSq, 1), saturating at 2^56.
  // ---------------------------------------------------------------------------
  logic       dv_valid;
  plds_quot_t dv_quot;
  plds_side_t dv_side;

  plds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mb_valid_q),
    .prod_i  (prod_q),
    .side_i  (mb_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------------------
  // S = E + ambient, capped; out of range keeps only the ambient term.
  // ---------------------------------------------------------------------------
  logic [S_W-1:0] s_sum [LANES];
  logic [S_W-1:0] s_d   [LANES];
  logic [S_W-1:0] s_q   [LANES];
  logic           s_valid_q;
  plds_side_t     s_side_q;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      s_sum[j] = {1'b0, dv_quot.q[j]} + AMB_Q24;
      priority if (dv_side.oor) begin
        s_d[j] = AMB_Q24;
      end else if (dv_quot.sat[j] || (s_sum[j] > S_CAP)) begin
        s_d[j] = S_CAP;
      end else begin
        s_d[j] = s_sum[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shade: material * alpha * S / 2^56, round half up, saturate.
  // ---------------------------------------------------------------------------
  localparam logic [S_W:0] RoundHalf = (S_W + 1)'(1) << 39;

  logic [15:0]    mat [LANES];
  logic [31:0]    ma_q  [LANES];
  logic [S_W-1:0] sh_s_q [LANES];
  logic [64:0]    phi_q [LANES];
  logic [55:0]    plo_q [LANES];
  logic           sh1_valid_q, sh2_valid_q, res_valid_q;
  logic [15:0]    sh1_alpha_q, sh2_alpha_q;
  logic [S_W-1:0] acc_sum [LANES];
  logic [S_W:0]   rnd [LANES];
  logic [15:0]    shade_val [LANES];
  plds_out_t      res_data_d, res_data_q;

  assign mat[0] = s_side_q.mat_red;
  assign mat[1] = s_side_q.mat_green;
  assign mat[2] = s_side_q.mat_blue;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      acc_sum[j] = {1'b0, phi_q[j][31:0], 24'b0} + {1'b0, plo_q[j]};
      rnd[j]     = {1'b0, acc_sum[j]} + RoundHalf;
      if ((phi_q[j][64:32] != '0) || (rnd[j][S_W:56] != '0)) begin
        shade_val[j] = '1;
      end else begin
        shade_val[j] = rnd[j][55:40];
      end
    end
    res_data_d.out_red   = shade_val[0];
    res_data_d.out_green = shade_val[1];
    res_data_d.out_blue  = shade_val[2];
    res_data_d.out_alpha = sh2_alpha_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      sh1_valid_q <= 1'b0;
      sh2_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s_valid_q   <= dv_valid;
      sh1_valid_q <= s_valid_q;
      sh2_valid_q <= sh1_valid_q;
      res_valid_q <= sh2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_side_q    <= dv_side;
    sh1_alpha_q <= s_side_q.mat_alpha;
    sh2_alpha_q <= sh1_alpha_q;
    res_data_q  <= res_data_d;
    for (int j = 0; j < LANES; j++) begin
      s_q[j]    <= s_d[j];
      ma_q[j]   <= 32'(mat[j]) * 32'(s_side_q.mat_alpha);
      sh_s_q[j] <= s_q[j];
      phi_q[j]  <= 65'(ma_q[j]) * 65'(sh_s_q[j][S_W-1:24]);
      plo_q[j]  <= 56'(ma_q[j]) * 56'(sh_s_q[j][23:0]);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // every result comes from a transaction taken on an earlier start, at the LATENCY depth of the pipe
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start, LATENCY))
    else $error("result without matching transaction");

  // alpha travels untouched through the whole pipe
  a_alpha : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_data_o.out_alpha == $past(in_data_i.mat_alpha, LATENCY)))
    else $error("alpha mismatch");

  // a lit point always has a nonzero light distance to divide by
  a_len_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rt_valid && (rt_tag.num != '0)) |-> (rt_len != '0))
    else $error("zero length for a nonzero n.L");

endmodule

>>> hdl/plds_isqrt.sv
module plds_isqrt import plds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [ROOT_IN_W-1:0] x_i,
  input  plds_root_tag_t       tag_i,
  output logic                 valid_o,
  output logic [LEN_W-1:0]     root_o,
  output plds_root_tag_t       tag_o
);

  // one root bit per stage
  logic [ROOT_W-1:0] x_q   [SQRT_STEPS];
  logic [ROOT_W-1:0] res_q [SQRT_STEPS];
  logic              valid_q [SQRT_STEPS];
  plds_root_tag_t    tag_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [ROOT_W-1:0] StepBit = ROOT_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [ROOT_W-1:0] x_in;
    logic [ROOT_W-1:0] res_in;
    logic [ROOT_W-1:0] trial;
    logic              v_in;
    plds_root_tag_t    t_in;

    if (i == 0) begin : g_first
      assign x_in   = {1'b0, x_i};
      assign res_in = '0;
      assign v_in   = valid_i;
      assign t_in   = tag_i;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign res_in = res_q[i-1];
      assign v_in   = valid_q[i-1];
      assign t_in   = tag_q[i-1];
    end

    assign trial = res_in + StepBit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[i] <= t_in;
      if (x_in >= trial) begin
        x_q[i]   <= x_in - trial;
        res_q[i] <= (res_in >> 1) + StepBit;
      end else begin
        x_q[i]   <= x_in;
        res_q[i] <= res_in >> 1;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][LEN_W-1:0];
  assign tag_o   = tag_q[SQRT_STEPS-1];

endmodule

>>> hdl/plds_div.sv
module plds_div import plds_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [LANES-1:0][PROD_W-1:0] prod_i,
  input  plds_side_t                  side_i,
  output logic                        valid_o,
  output plds_quot_t                  quot_o,
  output plds_side_t                  side_o
);

  // stage 0: overflow check, stages 1..EQ_W: one quotient bit each
  logic [REM_W-1:0] rem_q [EQ_W+1][LANES];
  logic [EQ_W-1:0]  acc_q [EQ_W+1][LANES];
  logic             sat_q [EQ_W+1][LANES];
  logic             valid_q [EQ_W+1];
  plds_side_t       side_q  [EQ_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
  end

  for (genvar j = 0; j < LANES; j++) begin : g_init
    always_ff @(posedge clk_i) begin
      sat_q[0][j] <= (side_i.div[DSQ_W-1:PRE_W] == '0) &&
                     (prod_i[j] >= {side_i.div[PRE_W-1:0], {EQ_W{1'b0}}});
      rem_q[0][j] <= {{(REM_W-PRE_W){1'b0}}, prod_i[j][PROD_W-1:EQ_W]};
      acc_q[0][j] <= prod_i[j][EQ_W-1:0];
    end
  end

  for (genvar k = 1; k <= EQ_W; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_q[k-1];
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [REM_W-1:0] shifted;
      logic             ge;

      assign shifted = {rem_q[k-1][j][REM_W-2:0], acc_q[k-1][j][EQ_W-1]};
      assign ge      = shifted >= {1'b0, side_q[k-1].div};

      always_ff @(posedge clk_i) begin
        sat_q[k][j] <= sat_q[k-1][j];
        rem_q[k][j] <= ge ? shifted - {1'b0, side_q[k-1].div} : shifted;
        acc_q[k][j] <= {acc_q[k-1][j][EQ_W-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      quot_o.sat[j] = sat_q[EQ_W][j];
      quot_o.q[j]   = acc_q[EQ_W][j];
    end
  end

  assign valid_o = valid_q[EQ_W];
  assign side_o  = side_q[EQ_W];

endmodule

>>> dv/point_light_diffuse_shader_top_tb.sv
`timescale 1ns / 100ps

module point_light_diffuse_shader_top_tb;
  import plds_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [63:0] AMBIENT     = 64'd83886;
  localparam logic [63:0] SUM_CAP     = 64'd1 << 56;
  localparam logic [63:0] NDOTL_CAP   = 64'd262143;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  plds_in_t         in_data_i = '0;
  logic             res_valid_o;
  plds_out_t        res_data_o;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  point_light_diffuse_shader_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Light state as the block should hold it.
  logic signed [15:0] light_x, light_y, light_z;
  logic [15:0]        light_col [3];
  logic [23:0]        light_pow;
  logic [15:0]        light_reach;

  plds_out_t   pixels_due[$];
  bit          failed = 1'b0;
  bit          gaps_on = 1'b1;
  int unsigned cycles = 0;

  // Bitwise integer square root.
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bit_v;
    res   = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // material * alpha * s / 2^56, round half up, saturate to Q0.16.
  function automatic logic [15:0] tint(logic [15:0] mat, logic [15:0] alpha,
                                       logic [63:0] s);
    logic [63:0] ma, hi, lo, phi, sum, r;
    ma = 64'(mat) * 64'(alpha);
    if (ma == 0) return 16'd0;
    if (s > SUM_CAP) s = SUM_CAP;
    hi  = s >> 24;
    lo  = s & 64'hFF_FFFF;
    phi = ma * hi;
    if (phi >= (64'd1 << 32)) return 16'hFFFF;
    sum = (phi << 24) + ma * lo;
    r   = (sum + (64'd1 << 39)) >> 40;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic plds_out_t shade_point(plds_in_t d);
    longint      lx, ly, lz, dot;
    logic [63:0] dsq, nd, dvs, e, s, reach2;
    logic [15:0] mat [3];
    logic [15:0] chan [3];
    plds_out_t   o;
    lx  = longint'(light_x) - longint'(d.point_x);
    ly  = longint'(light_y) - longint'(d.point_y);
    lz  = longint'(light_z) - longint'(d.point_z);
    dsq = lx * lx + ly * ly + lz * lz;
    mat[0] = d.mat_red;
    mat[1] = d.mat_green;
    mat[2] = d.mat_blue;
    reach2 = 64'(light_reach) * 64'(light_reach);
    if (light_reach != 0 && dsq > reach2) begin
      for (int j = 0; j < 3; j++) chan[j] = tint(mat[j], d.mat_alpha, AMBIENT);
    end else begin
      dot = longint'(d.normal_x) * lx + longint'(d.normal_y) * ly
          + longint'(d.normal_z) * lz;
      nd  = 0;
      dvs = (dsq != 0) ? dsq : 64'd1;
      if (dsq != 0 && dot > 0) begin
        nd = (64'(dot) << 10) / int_sqrt(dsq << 16);
        if (nd > NDOTL_CAP) nd = NDOTL_CAP;
      end
      for (int j = 0; j < 3; j++) begin
        e = (64'(light_col[j]) * nd * 64'(light_pow)) / dvs;
        s = (e >= SUM_CAP) ? SUM_CAP : e + AMBIENT;
        chan[j] = tint(mat[j], d.mat_alpha, s);
      end
    end
    o.out_red   = chan[0];
    o.out_green = chan[1];
    o.out_blue  = chan[2];
    o.out_alpha = d.mat_alpha;
    return o;
  endfunction

  // Scoreboard: every strobe must match the oldest pending pixel.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
    if (rst_ni && res_valid_o) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_data_o);
        failed <= 1'b1;
      end else begin
        if (res_data_o !== pixels_due[0]) begin
          $display("%0t: mismatch expected %h actual %h", $time, pixels_due[0],
                   res_data_o);
          failed <= 1'b1;
        end
        void'(pixels_due.pop_front());
      end
    end
  end

  // Light writes go in only with the pipe drained.
  task automatic write_light(plds_reg_e idx, logic [CFG_W-1:0] val);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LIGHT_POS_X:     light_x     = val[15:0];
      REG_LIGHT_POS_Y:     light_y     = val[15:0];
      REG_LIGHT_POS_Z:     light_z     = val[15:0];
      REG_LIGHT_RED:       light_col[0] = val[15:0];
      REG_LIGHT_GREEN:     light_col[1] = val[15:0];
      REG_LIGHT_BLUE:      light_col[2] = val[15:0];
      REG_LIGHT_INTENSITY: light_pow   = val;
      REG_LIGHT_RANGE:     light_reach = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_light(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                           logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [23:0] pw, logic [15:0] reach);
    logic [7:0] junk;
    junk = 8'($urandom);  // upper data bits are don't-care for 16 bit registers
    write_light(REG_LIGHT_POS_X, {junk, px});
    write_light(REG_LIGHT_POS_Y, {~junk, py});
    write_light(REG_LIGHT_POS_Z, {junk, pz});
    write_light(REG_LIGHT_RED, {~junk, r});
    write_light(REG_LIGHT_GREEN, {junk, g});
    write_light(REG_LIGHT_BLUE, {~junk, b});
    write_light(REG_LIGHT_INTENSITY, pw);
    write_light(REG_LIGHT_RANGE, {junk, reach});
  endtask

  // One transaction; expectation is either typed in or predicted.
  task automatic shade(plds_in_t d, bit known = 1'b0, plds_out_t want = '0);
    start     <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pixels_due.push_back(known ? want : shade_point(d));
    if (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Random surface point; mostly close to the light, half of them with the normal aimed at it.
  function automatic plds_in_t rand_point();
    plds_in_t d;
    int unsigned mode;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(9);
    if (mode < 7) begin
      d.point_x = light_x - 16'($signed($urandom_range(0, 2047)) - 1024);
      d.point_y = light_y - 16'($signed($urandom_range(0, 2047)) - 1024);
      d.point_z = light_z - 16'($signed($urandom_range(0, 2047)) - 1024);
      if (mode < 5) begin
        d.normal_x = (light_x - d.point_x) <<< $urandom_range(0, 4);
        d.normal_y = (light_y - d.point_y) <<< $urandom_range(0, 4);
        d.normal_z = (light_z - d.point_z) <<< $urandom_range(0, 4);
      end
    end
    return d;
  endfunction

  typedef struct {
    plds_in_t  d;
    bit        known;
    plds_out_t want;
  } shade_row_t;

  shade_row_t rows_dark[$];
  shade_row_t rows_lit[$];

  initial begin
    plds_in_t d;
    light_x = 0; light_y = 0; light_z = 0;
    light_col = '{default: 0};
    light_pow = 0;
    light_reach = 0;

    // Light at reset: black, so only ambient. Zero material or alpha gives zero.
    rows_dark.push_back('{'0, 1'b1, '0});
    rows_dark.push_back('{{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                           16'sh8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
                          1'b1, '0});
    rows_dark.push_back('{{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                           16'sh7FFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
                          1'b1, {16'h0, 16'h0, 16'h0, 16'hFFFF}});
    rows_dark.push_back('{{16'sh0100, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0,
                           16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF}, 1'b0, '0});

    // Lit cases: zero distance, facing, back-facing, grazing, near/far, extremes.
    rows_lit.push_back('{{16'sh0100, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0,
                          16'hFFFF, 16'h8000, 16'h1234, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh0, 16'sh0, 16'sh0, -16'sh4000, 16'sh0, 16'sh0,
                          16'hFFFF, 16'h8000, 16'h1234, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b0, '0});
    rows_lit.push_back('{{16'sh00FF, 16'sh0, 16'sh0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh8000, 16'sh8000, 16'sh8000, 16'sh4000, 16'sh4000,
                          16'sh4000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh0300, 16'sh0, 16'sh0, -16'sh4000, 16'sh0, 16'sh0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
    rows_lit.push_back('{{16'sh0, 16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1,
                         {16'h0, 16'h0, 16'h0, 16'h0}});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows_dark[i]) shade(rows_dark[i].d, rows_dark[i].known, rows_dark[i].want);
    start <= 1'b0;

    // Light at 1.0,0,0, full white, max intensity, range 2.0.
    set_light(16'h0100, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF,
              16'h0200);
    foreach (rows_lit[i]) shade(rows_lit[i].d, rows_lit[i].known, rows_lit[i].want);
    // Same points with a modest light and no range cutoff.
    start <= 1'b0;
    set_light(16'h0100, 16'h0, 16'h0, 16'h8000, 16'h4000, 16'h0001, 24'h00_0100,
              16'h0);
    foreach (rows_lit[i]) shade(rows_lit[i].d, rows_lit[i].known, rows_lit[i].want);

    // Random phases, each with its own light; extremes among them.
    for (int ph = 0; ph < 8; ph++) begin
      start <= 1'b0;
      case (ph)
        0: set_light(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     24'hFF_FFFF, 16'hFFFF);
        1: set_light(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h0, 24'h0, 16'h0);
        2: set_light(16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h8000, 16'h0100,
                     24'h00_0040, 16'h0001);
        default: set_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom),
                           ($urandom_range(1) ? 24'($urandom)
                                              : 24'($urandom_range(0, 4096))),
                           ($urandom_range(2) == 0) ? 16'h0
                                                    : 16'($urandom_range(0, 1536)));
      endcase
      gaps_on = (ph != 4);  // one long stretch back to back
      repeat (230) begin
        d = rand_point();
        shade(d);
      end
    end
    start <= 1'b0;

    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
